### hw/rtl/mbpb_pkg.sv
// ----------------------------------------------------------------------------
// mbpb_pkg
// Shared constants and types of the msb-first bit packer buffer.
// ----------------------------------------------------------------------------
package mbpb_pkg;

  localparam int BufBytes = 4096;
  localparam int MaxWidth = 32;
  localparam int NumWords = BufBytes / 4;
  localparam int BankDepth = NumWords / 2;
  localparam int WordAw = $clog2(NumWords);
  localparam int BankAw = $clog2(BankDepth);

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_PATCH  = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  // read-modify-write request to the merge unit
  typedef struct packed {
    logic [WordAw-1:0] word;
    logic [4:0]        offs;
    logic [31:0]       value;
    logic [5:0]        nbits;
    logic [12:0]       used;
  } merge_req_t;

  // merged word pair, hi is the word at the lower address
  typedef struct packed {
    logic [31:0] hi_data;
    logic [31:0] lo_data;
    logic        hi_we;
    logic        lo_we;
  } merge_res_t;

endpackage

### hw/rtl/msb_first_bit_packer_buffer.sv
// ----------------------------------------------------------------------------
// msb_first_bit_packer_buffer
// Byte buffer written as an msb-first bitstream, with append, patch, clear
// and byte read actions.
// ----------------------------------------------------------------------------
// Usage: one transaction on the s_ side carries one action (tuser) and its
// operands (tdata); each action returns exactly one transaction on the m_
// side with the status and the counters after the action.
// Timing: the block works on one item at a time. On the accept edge both
// word banks are read; in the execute state the word pair is merged, written
// back and the result is registered. The read and the write of the
// single-port word banks fall in separate states. s_tready rises again in the
// same cycle as m_tvalid for that result.
// Storage: two banks of 32-bit words (even and odd word addresses), so any
// 32-bit field at any bit offset touches one word of each bank.
// Reset clears the state, m_tvalid, the cursor, the size and the overflow flag
// but not the word banks; bytes at or past the used size always read as zero,
// so there is no clearing pass and a clear takes the same steps as any action.
// Stall: the result register holds while m_tready is low; an item that
// finishes behind it waits in the execute state and no new item is taken
// until it moves on.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_buffer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // value[31:0], bit_count[39:32], bit_position[54:40], read_index[66:55]
  input  logic [71:0] s_tdata,
  // action[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // ok[0], read_data[8:1], bytes_used[21:9], bits_used[37:22],
  // overflow_flag[38]
  output logic [39:0] m_tdata
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state, state_next;

  logic [15:0] cursor, cursor_next;
  logic [12:0] used, used_next;
  logic        sticky, sticky_next;

  logic [1:0]                  act;
  logic [31:0]                 value;
  logic [7:0]                  nbits;
  logic [14:0]                 bpos;
  logic [11:0]                 ridx;
  logic [mbpb_pkg::WordAw-1:0] word;
  logic [4:0]                  offs;

  logic                        accept;
  logic                        finish;
  logic [15:0]                 start_in;
  logic [mbpb_pkg::WordAw-1:0] word_in;
  logic [mbpb_pkg::WordAw-1:0] word_sel;

  logic                        even_en, odd_en, even_we, odd_we;
  logic [mbpb_pkg::BankAw-1:0] even_addr, odd_addr;
  logic [31:0]                 even_wdata, odd_wdata, even_rdata, odd_rdata;
  logic [31:0]                 old_hi, old_lo;

  mbpb_pkg::merge_req_t        mreq;
  mbpb_pkg::merge_res_t        mres;

  logic        is_wr, n_zero, n_big, app_fit, pat_fit, do_write, ok;
  logic [16:0] app_end;
  logic [13:0] app_need;
  logic [15:0] pat_end;
  logic [7:0]  rbyte;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign finish   = (state == ST_EXEC) && (!m_tvalid || m_tready);

  // word address of the first bit touched by the incoming item
  assign start_in = (s_tuser == mbpb_pkg::ACT_APPEND) ? cursor : {1'b0, s_tdata[54:40]};
  assign word_in  = (s_tuser == mbpb_pkg::ACT_READ) ? s_tdata[55 + 2 +: mbpb_pkg::WordAw]
                                                     : start_in[5 +: mbpb_pkg::WordAw];
  assign word_sel = (state == ST_IDLE) ? word_in : word;

  assign even_addr = word_sel[mbpb_pkg::WordAw-1:1] + mbpb_pkg::BankAw'(word_sel[0]);
  assign odd_addr  = word_sel[mbpb_pkg::WordAw-1:1];

  assign old_hi = word[0] ? odd_rdata : even_rdata;
  assign old_lo = word[0] ? even_rdata : odd_rdata;

  assign mreq.word  = word;
  assign mreq.offs  = offs;
  assign mreq.value = value;
  assign mreq.nbits = nbits[5:0];
  assign mreq.used  = used;

  mbpb_merge u_merge (
    .req    (mreq),
    .old_hi (old_hi),
    .old_lo (old_lo),
    .res    (mres)
  );

  assign even_we    = finish && do_write && (word[0] ? mres.lo_we : mres.hi_we);
  assign odd_we     = finish && do_write && (word[0] ? mres.hi_we : mres.lo_we);
  assign even_wdata = word[0] ? mres.lo_data : mres.hi_data;
  assign odd_wdata  = word[0] ? mres.hi_data : mres.lo_data;
  assign even_en    = accept || even_we;
  assign odd_en     = accept || odd_we;

  mbpb_ram #(.DEPTH(mbpb_pkg::BankDepth), .WIDTH(32)) u_even (
    .clk   (clk),
    .en    (even_en),
    .we    (even_we),
    .addr  (even_addr),
    .wdata (even_wdata),
    .rdata (even_rdata)
  );

  mbpb_ram #(.DEPTH(mbpb_pkg::BankDepth), .WIDTH(32)) u_odd (
    .clk   (clk),
    .en    (odd_en),
    .we    (odd_we),
    .addr  (odd_addr),
    .wdata (odd_wdata),
    .rdata (odd_rdata)
  );

  // action decode and counter updates
  always_comb begin
    is_wr    = act inside {mbpb_pkg::ACT_APPEND, mbpb_pkg::ACT_PATCH};
    n_zero   = (nbits == 8'd0);
    n_big    = (nbits > 8'(mbpb_pkg::MaxWidth));
    app_end  = {1'b0, cursor} + 17'(nbits);
    app_need = 14'((app_end + 17'd7) >> 3);
    app_fit  = (app_need <= 14'(mbpb_pkg::BufBytes));
    pat_end  = {1'b0, bpos} + 16'(nbits);
    pat_fit  = (pat_end <= {used, 3'b000});
    do_write = is_wr && !n_zero && !n_big &&
               ((act == mbpb_pkg::ACT_APPEND) ? app_fit : pat_fit);
    ok       = !(is_wr && !n_zero && !do_write);
    rbyte    = old_hi[8 * (3 - 32'(ridx[1:0])) +: 8];

    cursor_next = cursor;
    used_next   = used;
    sticky_next = sticky;
    case (act)
      mbpb_pkg::ACT_APPEND, mbpb_pkg::ACT_PATCH: begin
        if (!n_zero && n_big) begin
          sticky_next = 1'b1;
        end
        if (do_write && (act == mbpb_pkg::ACT_APPEND)) begin
          cursor_next = app_end[15:0];
          if (app_need[12:0] > used) begin
            used_next = app_need[12:0];
          end
        end
      end
      mbpb_pkg::ACT_CLEAR: begin
        cursor_next = 16'd0;
        used_next   = 13'd0;
        sticky_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cursor   <= 16'd0;
      used     <= 13'd0;
      sticky   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        cursor   <= cursor_next;
        used     <= used_next;
        sticky   <= sticky_next;
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      act   <= s_tuser;
      value <= s_tdata[31:0];
      nbits <= s_tdata[39:32];
      bpos  <= s_tdata[54:40];
      ridx  <= s_tdata[66:55];
      word  <= word_in;
      offs  <= start_in[4:0];
    end
    if (finish) begin
      m_tdata[0]     <= ok;
      m_tdata[8:1]   <= ((act == mbpb_pkg::ACT_READ) && (13'(ridx) < used)) ? rbyte : 8'd0;
      m_tdata[21:9]  <= used_next;
      m_tdata[37:22] <= cursor_next;
      m_tdata[38]    <= sticky_next;
      m_tdata[39]    <= 1'b0;
    end
  end

  // size always covers exactly the bytes touched by the cursor
  assert property (@(posedge clk) disable iff (rst)
    used == 13'((cursor + 16'd7) >> 3))
    else $error("used size out of step with cursor");

  assert property (@(posedge clk) disable iff (rst)
    used <= 13'(mbpb_pkg::BufBytes))
    else $error("used size beyond buffer");

  // one item at a time: no accept in the cycle after an accept
  assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("item accepted while another is at work");

  // a bank is never written outside the execute step
  assert property (@(posedge clk) disable iff (rst)
    (even_we || odd_we) |-> (state == ST_EXEC) && !accept)
    else $error("bank write outside execute");

endmodule

### hw/rtl/mbpb_ram.sv
// ----------------------------------------------------------------------------
// mbpb_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module mbpb_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

### hw/rtl/mbpb_merge.sv
// ----------------------------------------------------------------------------
// mbpb_merge
// Inserts up to 32 bits msb-first into a pair of adjacent 32-bit words.
// ----------------------------------------------------------------------------
module mbpb_merge (
  input  mbpb_pkg::merge_req_t req,
  input  logic [31:0]          old_hi,
  input  logic [31:0]          old_lo,
  output mbpb_pkg::merge_res_t res
);

  logic [63:0]                 old_win;
  logic [63:0]                 ins;
  logic [63:0]                 mask;
  logic [63:0]                 new_win;
  logic [6:0]                  lsh;
  logic [mbpb_pkg::WordAw:0]   word_lo;

  assign word_lo = {1'b0, req.word} + (mbpb_pkg::WordAw + 1)'(1);

  // bytes at or past the used size hold stale data and count as zero
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (13'({req.word, 2'(j)}) < req.used) begin
        old_win[32 + 8 * (3 - j) +: 8] = old_hi[8 * (3 - j) +: 8];
      end else begin
        old_win[32 + 8 * (3 - j) +: 8] = 8'd0;
      end
      if (13'({word_lo, 2'(j)}) < req.used) begin
        old_win[8 * (3 - j) +: 8] = old_lo[8 * (3 - j) +: 8];
      end else begin
        old_win[8 * (3 - j) +: 8] = 8'd0;
      end
    end
  end

  assign lsh     = 7'd64 - {1'b0, req.nbits};
  assign ins     = ({32'd0, req.value} << lsh) >> req.offs;
  assign mask    = (~(64'hFFFF_FFFF_FFFF_FFFF >> req.nbits)) >> req.offs;
  assign new_win = (old_win & ~mask) | (ins & mask);

  assign res.hi_data = new_win[63:32];
  assign res.lo_data = new_win[31:0];
  assign res.hi_we   = |mask[63:32];
  assign res.lo_we   = |mask[31:0];

endmodule

### tb/sv/tb_msb_first_bit_packer_buffer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_msb_first_bit_packer_buffer
// Drives append, patch, clear and byte read transactions into the packer with
// random idling on both sides, keeps a shadow copy of the byte buffer and its
// counters, and checks every status transaction field by field.
// ----------------------------------------------------------------------------
module tb_msb_first_bit_packer_buffer;

  localparam int WatchdogLimit = 400;
  localparam int RandomItems = 40;
  localparam int CalmItems = 15;
  localparam int TailCycles = 8;

  typedef struct {
    mbpb_pkg::action_t act;
    logic [31:0]       value;
    logic [7:0]        nbits;
    logic [14:0]       bpos;
    logic [11:0]       ridx;
  } bit_op_t;

  typedef struct {
    logic        ok;
    logic [7:0]  rdata;
    logic [12:0] bytes;
    logic [15:0] bits;
    logic        ovf;
  } status_t;

  class packer_scoreboard;
    logic [7:0]  store [mbpb_pkg::BufBytes];
    int unsigned cursor;
    int unsigned used;
    logic        sticky;
    status_t     status_due [$];
    int          errors;

    function new();
      foreach (store[i]) store[i] = 8'h00;
      cursor = 0;
      used = 0;
      sticky = 1'b0;
      errors = 0;
    endfunction

    // stream bit p sits in byte p/8 at bit 7-(p%8), top bit of the field first
    function void write_bits(int unsigned start, logic [31:0] value, int unsigned n);
      int unsigned pos;
      for (int unsigned k = 0; k < n; k++) begin
        pos = start + k;
        store[pos >> 3][7 - (pos & 7)] = value[n - 1 - k];
      end
    endfunction

    function void take_action(bit_op_t op);
      status_t     st;
      int unsigned n;
      int unsigned end_bit;
      int unsigned need;
      st.ok = 1'b1;
      st.rdata = 8'h00;
      n = op.nbits;
      case (op.act)
        mbpb_pkg::ACT_APPEND, mbpb_pkg::ACT_PATCH: begin
          if (n > mbpb_pkg::MaxWidth) begin
            sticky = 1'b1;
            st.ok = 1'b0;
          end else if (n != 0) begin
            if (op.act == mbpb_pkg::ACT_APPEND) begin
              end_bit = cursor + n;
              need = (end_bit + 7) >> 3;
              if (need > mbpb_pkg::BufBytes) begin
                st.ok = 1'b0;
              end else begin
                write_bits(cursor, op.value, n);
                cursor = end_bit;
                if (need > used) used = need;
              end
            end else if (op.bpos + n > used * 8) begin
              st.ok = 1'b0;
            end else begin
              write_bits(op.bpos, op.value, n);
            end
          end
        end
        mbpb_pkg::ACT_CLEAR: begin
          for (int i = 0; i < used; i++) store[i] = 8'h00;
          cursor = 0;
          used = 0;
          sticky = 1'b0;
        end
        default: begin
          if (op.ridx < used) st.rdata = store[op.ridx];
        end
      endcase
      st.bytes = 13'(used);
      st.bits = 16'(cursor);
      st.ovf = sticky;
      status_due.push_back(st);
    endfunction

    function void field_check(string name, int unsigned want, logic [15:0] got);
      if (got !== 16'(want)) begin
        $error("%s expected %0d actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_status(logic [39:0] d);
      status_t want;
      if (status_due.size() == 0) begin
        $error("status transaction with nothing expected: %h", d);
        errors++;
        return;
      end
      want = status_due.pop_front();
      field_check("ok", want.ok, 16'(d[0]));
      field_check("read_data", want.rdata, 16'(d[8:1]));
      field_check("bytes_used", want.bytes, 16'(d[21:9]));
      field_check("bits_used", want.bits, d[37:22]);
      field_check("overflow_flag", want.ovf, 16'(d[38]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  // value[31:0], bit_count[39:32], bit_position[54:40], read_index[66:55]
  logic [71:0] s_tdata;
  // action[1:0]
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  // ok[0], read_data[8:1], bytes_used[21:9], bits_used[37:22], overflow_flag[38]
  logic [39:0] m_tdata;

  packer_scoreboard shadow = new();
  bit               calm = 1'b0;
  int               quiet = 0;

  msb_first_bit_packer_buffer u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // one action per transaction; the shadow is updated as soon as it is taken
  task automatic send_op(input mbpb_pkg::action_t act, input int unsigned value,
                         input int unsigned nbits, input int unsigned bpos,
                         input int unsigned ridx);
    bit_op_t op;
    op.act = act;
    op.value = value;
    op.nbits = 8'(nbits);
    op.bpos = 15'(bpos);
    op.ridx = 12'(ridx);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op.act;
    s_tdata <= {5'b0, op.ridx, op.bpos, op.nbits, op.value};
    do @(posedge clk); while (!s_tready);
    shadow.take_action(op);
  endtask

  task automatic send_random(input bit keep_stream);
    int pick;
    int n;
    int span;
    pick = $urandom_range(0, 99);
    span = shadow.used * 8;
    if (pick < 40) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                      : $urandom_range(1, mbpb_pkg::MaxWidth);
      send_op(mbpb_pkg::ACT_APPEND, $urandom, n, $urandom, $urandom);
    end else if (pick < 65) begin
      if (span > 0 && $urandom_range(0, 4) != 0) begin
        n = $urandom_range(1, (span < mbpb_pkg::MaxWidth) ? span : mbpb_pkg::MaxWidth);
        // now and then land right on the end of the used bytes or one past it
        if ($urandom_range(0, 5) == 0)
          send_op(mbpb_pkg::ACT_PATCH, $urandom, n, span - n + $urandom_range(0, 1),
                  $urandom);
        else
          send_op(mbpb_pkg::ACT_PATCH, $urandom, n, $urandom_range(0, span - n), $urandom);
      end else begin
        send_op(mbpb_pkg::ACT_PATCH, $urandom, $urandom_range(0, 255), $urandom, $urandom);
      end
    end else if (pick < 97 || keep_stream) begin
      if ($urandom_range(0, 3) != 0)
        send_op(mbpb_pkg::ACT_READ, $urandom, $urandom, $urandom,
                $urandom_range(0, shadow.used + 3));
      else
        send_op(mbpb_pkg::ACT_READ, $urandom, $urandom, $urandom,
                $urandom_range(0, mbpb_pkg::BufBytes - 1));
    end else begin
      send_op(mbpb_pkg::ACT_CLEAR, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  // packs the buffer to capacity, probes the full state, then clears it
  task automatic fill_buffer();
    int n;
    send_op(mbpb_pkg::ACT_CLEAR, $urandom, $urandom, $urandom, $urandom);
    // a lead-in shorter than a word makes full-width appends straddle two words
    send_op(mbpb_pkg::ACT_APPEND, $urandom, $urandom_range(1, mbpb_pkg::MaxWidth - 1),
            $urandom, $urandom);
    while (shadow.cursor + mbpb_pkg::MaxWidth <= mbpb_pkg::BufBytes * 8) begin
      if ($urandom_range(0, 63) == 0) begin
        send_random(1'b1);
      end else begin
        send_op(mbpb_pkg::ACT_APPEND, $urandom, mbpb_pkg::MaxWidth, $urandom, $urandom);
      end
    end
    repeat (2) send_op(mbpb_pkg::ACT_APPEND, $urandom, $urandom_range(1, mbpb_pkg::MaxWidth),
                       $urandom, $urandom);
    n = mbpb_pkg::BufBytes * 8 - shadow.cursor;
    if (n > 0) send_op(mbpb_pkg::ACT_APPEND, $urandom, n, $urandom, $urandom);
    send_op(mbpb_pkg::ACT_APPEND, $urandom, 1, $urandom, $urandom);
    send_op(mbpb_pkg::ACT_READ, $urandom, $urandom, $urandom, mbpb_pkg::BufBytes - 1);
    send_op(mbpb_pkg::ACT_PATCH, $urandom, 8, mbpb_pkg::BufBytes * 8 - 8, $urandom);
    send_op(mbpb_pkg::ACT_PATCH, $urandom, 1, mbpb_pkg::BufBytes * 8 - 1, $urandom);
    send_op(mbpb_pkg::ACT_READ, $urandom, $urandom, $urandom, mbpb_pkg::BufBytes - 1);
    repeat (4) send_random(1'b1);
    send_op(mbpb_pkg::ACT_CLEAR, $urandom, $urandom, $urandom, $urandom);
    send_op(mbpb_pkg::ACT_READ, $urandom, $urandom, $urandom, mbpb_pkg::BufBytes - 1);
  endtask

  task automatic directed_ops();
    send_op(mbpb_pkg::ACT_READ, 0, 0, 0, 0);
    send_op(mbpb_pkg::ACT_APPEND, 32'hFFFF_FFFF, 0, 0, 0);
    send_op(mbpb_pkg::ACT_APPEND, 32'h0000_0001, 1, 0, 0);
    send_op(mbpb_pkg::ACT_APPEND, 32'hFFFF_FFFF, 32, 0, 0);
    send_op(mbpb_pkg::ACT_APPEND, 32'h0000_0000, 32, 0, 0);
    send_op(mbpb_pkg::ACT_APPEND, 32'h5A5A_A5A5, 7, 15'h7FFF, 12'hFFF);
    send_op(mbpb_pkg::ACT_APPEND, 32'hFFFF_FFFF, 33, 0, 0);
    send_op(mbpb_pkg::ACT_APPEND, 32'hFFFF_FFFF, 255, 0, 0);
    send_op(mbpb_pkg::ACT_PATCH, 32'hFFFF_FFFF, 0, 0, 0);
    send_op(mbpb_pkg::ACT_PATCH, 32'h8000_0001, 32, 0, 0);
    send_op(mbpb_pkg::ACT_PATCH, 32'h0000_000F, 4, shadow.used * 8 - 4, 0);
    send_op(mbpb_pkg::ACT_PATCH, 32'h0000_000F, 4, shadow.used * 8 - 3, 0);
    send_op(mbpb_pkg::ACT_PATCH, 32'h0000_0001, 1, 15'h7FFF, 0);
    send_op(mbpb_pkg::ACT_PATCH, 32'h0000_0000, 40, 0, 0);
    send_op(mbpb_pkg::ACT_READ, 0, 0, 0, 0);
    send_op(mbpb_pkg::ACT_READ, 0, 0, 0, 1);
    send_op(mbpb_pkg::ACT_READ, 0, 0, 0, shadow.used - 1);
    send_op(mbpb_pkg::ACT_READ, 0, 0, 0, shadow.used);
    send_op(mbpb_pkg::ACT_READ, 0, 0, 0, mbpb_pkg::BufBytes - 1);
    send_op(mbpb_pkg::ACT_CLEAR, 0, 0, 0, 0);
    send_op(mbpb_pkg::ACT_READ, 0, 0, 0, 0);
    send_op(mbpb_pkg::ACT_APPEND, 32'h0000_1ABC, 13, 0, 0);
    send_op(mbpb_pkg::ACT_READ, 0, 0, 0, 0);
    send_op(mbpb_pkg::ACT_READ, 0, 0, 0, 1);
  endtask

  initial begin
    int sent;
    bit filled;
    sent = 0;
    filled = 1'b0;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= mbpb_pkg::ACT_APPEND;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    directed_ops();
    while (sent < RandomItems) begin
      if (!filled && sent >= RandomItems / 2) begin
        fill_buffer();
        filled = 1'b1;
      end
      if (RandomItems - sent <= CalmItems) calm = 1'b1;
      send_random(1'b0);
      sent++;
    end
    s_tvalid <= 1'b0;
    while (shadow.status_due.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (shadow.errors == 0) begin
      $display("[msb_first_bit_packer_buffer] OK");
    end else begin
      $display("[msb_first_bit_packer_buffer] ERROR");
    end
    $finish;
  end

  // result side back-pressure in bursts
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) shadow.check_status(m_tdata);
  end

  // no transaction on either side for too long means the block is stuck
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= WatchdogLimit) begin
      $display("[msb_first_bit_packer_buffer] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule

### filelist.f
hw/rtl/mbpb_pkg.sv
hw/rtl/mbpb_ram.sv
hw/rtl/mbpb_merge.sv
hw/rtl/msb_first_bit_packer_buffer.sv
tb/sv/tb_msb_first_bit_packer_buffer.sv
